### rtl/bta_pkg.sv
package bta_pkg;

    // Fixed field widths of one item and of one result
    localparam int DEF_WORD_TRITS = 12;
    localparam int OP_W           = 3;
    localparam int WORD_W         = 24;
    localparam int CNT_W          = 4;
    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_SHL = 3'd4,
        OP_SHR = 3'd5,
        OP_ABS = 3'd6
    } op_t;

    // Trit codes, two bits per trit
    localparam logic [1:0] TRIT_ZERO = 2'b00;
    localparam logic [1:0] TRIT_POS  = 2'b01;
    localparam logic [1:0] TRIT_NEG  = 2'b10;

    // Sign as a signed two-bit value
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [CNT_W-1:0]  shift_count;
    } item_t;

    typedef struct packed {
        logic              result_zero;
        logic signed [1:0] result_sign;
        logic [WORD_W-1:0] result_word;
    } res_t;

    localparam int RES_W = $bits(res_t);

endpackage

### rtl/bta_alu.sv
module bta_alu #(
    parameter int WORD_TRITS = bta_pkg::DEF_WORD_TRITS
) (
    input  bta_pkg::item_t item,
    output bta_pkg::res_t  res
);
    import bta_pkg::*;

    localparam int W      = 2 * WORD_TRITS;
    localparam int IN_W   = (W < WORD_W) ? W : WORD_W;
    localparam int LVL    = $clog2(WORD_TRITS);
    localparam int LEAVES = 2 ** LVL;

    function automatic logic signed [2:0] trit_val(input logic [1:0] t);
        logic signed [2:0] v;
        case (t)
            TRIT_POS: v = 3'sd1;
            TRIT_NEG: v = -3'sd1;
            default:  v = 3'sd0;
        endcase
        return v;
    endfunction

    // Load a field into a word; the unused code 11 reads as zero
    function automatic logic [W-1:0] load_word(input logic [WORD_W-1:0] f);
        logic [W-1:0] w;
        w = '0;
        w[IN_W-1:0] = f[IN_W-1:0];
        for (int i = 0; i < WORD_TRITS; i++) begin
            if (w[2*i +: 2] == 2'b11) begin
                w[2*i +: 2] = TRIT_ZERO;
            end
        end
        return w;
    endfunction

    function automatic logic [W-1:0] neg_word(input logic [W-1:0] x);
        logic [W-1:0] w;
        for (int i = 0; i < WORD_TRITS; i++) begin
            w[2*i +: 2] = {x[2*i], x[2*i+1]};
        end
        return w;
    endfunction

    // Ripple-carry add; carry out of the top trit is dropped
    function automatic logic [W-1:0] add_word(input logic [W-1:0] x, input logic [W-1:0] y);
        logic [W-1:0]      w;
        logic [1:0]        c;
        logic signed [2:0] sv;
        c = TRIT_ZERO;
        for (int i = 0; i < WORD_TRITS; i++) begin
            sv = trit_val(x[2*i +: 2]) + trit_val(y[2*i +: 2]) + trit_val(c);
            if (sv > 3'sd1) begin
                sv = sv - 3'sd3;
                c  = TRIT_POS;
            end else if (sv < -3'sd1) begin
                sv = sv + 3'sd3;
                c  = TRIT_NEG;
            end else begin
                c  = TRIT_ZERO;
            end
            case (sv)
                3'sd1:   w[2*i +: 2] = TRIT_POS;
                -3'sd1:  w[2*i +: 2] = TRIT_NEG;
                default: w[2*i +: 2] = TRIT_ZERO;
            endcase
        end
        return w;
    endfunction

    // Highest nonzero trit wins
    function automatic logic [1:0] top_trit(input logic [W-1:0] x);
        logic [1:0] s;
        s = TRIT_ZERO;
        for (int i = 0; i < WORD_TRITS; i++) begin
            if (x[2*i +: 2] != TRIT_ZERO) begin
                s = x[2*i +: 2];
            end
        end
        return s;
    endfunction

    logic [W-1:0]     a_w;
    logic [W-1:0]     b_w;
    logic [W-1:0]     r_w;
    logic [1:0]       r_top;
    logic [CNT_W:0]   shamt;
    logic             shift_big;
    logic [W-1:0]     node [0:2*LEAVES-2];

    assign a_w       = load_word(item.operand_a);
    assign b_w       = load_word(item.operand_b);
    assign shamt     = {item.shift_count, 1'b0};
    assign shift_big = 32'(item.shift_count) >= WORD_TRITS;

    // Multiply: signed partial products at the leaves, registered-free adder tree above
    for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
        if (i < WORD_TRITS) begin : g_pp
            logic [W-1:0] pp;
            assign pp = b_w << (2 * i);
            assign node[LEAVES-1+i] = (a_w[2*i +: 2] == TRIT_POS) ? pp :
                                      (a_w[2*i +: 2] == TRIT_NEG) ? neg_word(pp) : '0;
        end else begin : g_pad
            assign node[LEAVES-1+i] = '0;
        end
    end

    for (genvar k = 0; k < LEAVES - 1; k++) begin : g_tree
        assign node[k] = add_word(node[2*k+1], node[2*k+2]);
    end

    always_comb begin
        case (item.op)
            OP_ADD: r_w = add_word(a_w, b_w);
            OP_SUB: r_w = add_word(a_w, neg_word(b_w));
            OP_NEG: r_w = neg_word(a_w);
            OP_MUL: r_w = node[0];
            OP_SHL: r_w = shift_big ? '0 : (a_w << shamt);
            OP_SHR: r_w = shift_big ? '0 : (a_w >> shamt);
            OP_ABS: r_w = (top_trit(a_w) == TRIT_NEG) ? neg_word(a_w) : a_w;
            default: r_w = '0;
        endcase
    end

    assign r_top = top_trit(r_w);

    if (W >= WORD_W) begin : g_word_trunc
        assign res.result_word = r_w[WORD_W-1:0];
    end else begin : g_word_ext
        assign res.result_word = {{(WORD_W-W){1'b0}}, r_w};
    end

    always_comb begin
        case (r_top)
            TRIT_POS: res.result_sign = SIGN_POS;
            TRIT_NEG: res.result_sign = SIGN_NEG;
            default:  res.result_sign = SIGN_ZERO;
        endcase
    end

    assign res.result_zero = (r_w == '0);

endmodule

### rtl/balanced_ternary_word_alu_core.sv
// Balanced-ternary word ALU: add, subtract, negate, multiply, shifts, absolute value.
// Each item passes through the operand register, then the result register; m_tvalid
// rises once the item has been loaded into the result register.
// Throughput: 1 item per cycle while m_tready stays high; the operand register and the result register each
// hold one item, and each advances whenever the stage after it is empty or emptying.
// Reset: synchronous, active low; clears both valid flags, payload registers are not reset.
module balanced_ternary_word_alu_core #(
    parameter int WORD_TRITS = bta_pkg::DEF_WORD_TRITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // s_tdata, lowest bit up: op[2:0], operand_a[26:3], operand_b[50:27],
    // shift_count[54:51], zero pad[55]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bta_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata, lowest bit up: result_word[23:0], result_sign[25:24],
    // result_zero[26], zero pad[31:27]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bta_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bta_pkg::*;

    // Operand stage
    logic   in_valid_reg;
    logic   in_valid_next;
    item_t  item_reg;
    item_t  item_in;

    // Result stage
    logic   out_valid_reg;
    logic   out_valid_next;
    res_t   res_reg;
    res_t   res_calc;

    logic   out_ready;

    // Result register frees up when empty or being taken this cycle
    assign out_ready = !out_valid_reg || m_tready;
    // Operand register frees up when empty or its item moves on this cycle
    assign s_tready  = !in_valid_reg || out_ready;

    // Unpack the incoming item
    assign item_in.op          = op_t'(s_tdata[OP_W-1:0]);
    assign item_in.operand_a   = s_tdata[OP_W +: WORD_W];
    assign item_in.operand_b   = s_tdata[OP_W+WORD_W +: WORD_W];
    assign item_in.shift_count = s_tdata[OP_W+2*WORD_W +: CNT_W];

    always_comb begin
        // Take a new item whenever the stage can advance, else hold
        in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
        out_valid_next = out_ready ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_in;
        end
        if (out_ready && in_valid_reg) begin
            res_reg <= res_calc;
        end
    end

    // All arithmetic for one item sits between the two registers
    bta_alu #(
        .WORD_TRITS (WORD_TRITS)
    ) u_alu (
        .item (item_reg),
        .res  (res_calc)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RES_W){1'b0}}, res_reg};

endmodule

### rtl/bta_checker.sv
module bta_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [bta_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bta_pkg::M_TDATA_W-1:0] m_tdata
);
    import bta_pkg::*;

    logic [WORD_W-1:0] word_w;
    logic signed [1:0] sign_w;
    logic              zero_w;

    assign word_w = m_tdata[WORD_W-1:0];
    assign sign_w = m_tdata[WORD_W +: 2];
    assign zero_w = m_tdata[WORD_W+2];

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Zero flag and sign agree
    a_zero_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (zero_w == (sign_w == SIGN_ZERO)))
        else $error("zero flag disagrees with sign");

    // A zero result shows no nonzero trit
    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && zero_w |-> word_w == '0)
        else $error("zero flag set on nonzero word");

    // Sign is never the unused code
    a_sign_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> sign_w != 2'sb10)
        else $error("unused sign code");

    // Reset drains the result stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind balanced_ternary_word_alu_core bta_checker u_bta_checker (.*);

### bench/bta_alu_checker.sv
`timescale 1ns / 100ps
module bta_alu_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bta_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bta_pkg::M_TDATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            results_owed,
    output int                            results_checked
);
    import bta_pkg::*;

    localparam int     NT       = DEF_WORD_TRITS;
    localparam longint WRAP_MOD = longint'(3) ** NT;
    localparam longint HALF_MOD = (WRAP_MOD - 1) / 2;

    res_t expected_results [$];

    initial begin
        fail_count      = 0;
        results_owed    = 0;
        results_checked = 0;
    end

    function automatic int trit_val(logic [1:0] code);
        case (code)
            TRIT_POS: return 1;
            TRIT_NEG: return -1;
            default:  return 0;     // the spare pair reads as zero
        endcase
    endfunction

    // Integer value of trits lo..hi of a word, trit lo weighing one.
    function automatic longint trits_value(logic [WORD_W-1:0] w, int lo, int hi);
        longint v;
        v = 0;
        for (int i = hi; i >= lo; i--)
            v = v * 3 + trit_val(w[2*i +: 2]);
        return v;
    endfunction

    // Drop every trit above the word: reduce into the balanced range.
    function automatic longint wrap_word(longint v);
        longint r;
        r = v % WRAP_MOD;
        if (r > HALF_MOD)
            r -= WRAP_MOD;
        else if (r < -HALF_MOD)
            r += WRAP_MOD;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] word_of(longint v);
        logic [WORD_W-1:0] w;
        longint            d;
        w = '0;
        for (int i = 0; i < NT; i++) begin
            d = v % 3;
            if (d > 1)
                d -= 3;
            else if (d < -1)
                d += 3;
            v = (v - d) / 3;
            w[2*i +: 2] = (d > 0) ? TRIT_POS : ((d < 0) ? TRIT_NEG : TRIT_ZERO);
        end
        return w;
    endfunction

    function automatic res_t ternary_alu_eval(logic [OP_W-1:0] op, logic [WORD_W-1:0] a,
                                              logic [WORD_W-1:0] b, logic [CNT_W-1:0] cnt);
        longint va;
        longint vb;
        longint r;
        int     n;
        res_t   res;
        va = trits_value(a, 0, NT - 1);
        vb = trits_value(b, 0, NT - 1);
        n  = int'(cnt);
        r  = 0;
        case (op)
            OP_ADD: r = wrap_word(va + vb);
            OP_SUB: r = wrap_word(va - vb);
            OP_NEG: r = -va;
            OP_MUL: r = wrap_word(va * vb);
            OP_SHL: if (n < NT) r = trits_value(a, 0, NT - 1 - n) * (longint'(3) ** n);
            OP_SHR: if (n < NT) r = trits_value(a, n, NT - 1);
            OP_ABS: r = (va < 0) ? -va : va;
            default: r = 0;
        endcase
        res.result_word = word_of(r);
        res.result_sign = (r > 0) ? SIGN_POS : ((r < 0) ? SIGN_NEG : SIGN_ZERO);
        res.result_zero = (r == 0);
        return res;
    endfunction

    always @(posedge aclk) begin
        res_t want;
        res_t got;
        if (!aresetn) begin
            expected_results.delete();
        end else begin
            // Retire first so an item accepted on this edge can never match itself.
            if (m_tvalid && m_tready) begin
                got = m_tdata[RES_W-1:0];
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: m_tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.result_word !== want.result_word) begin
                        $error("result_word: expected %h, got %h",
                               want.result_word, got.result_word);
                        fail_count++;
                    end
                    if (got.result_sign !== want.result_sign) begin
                        $error("result_sign: expected %0d, got %0d",
                               want.result_sign, got.result_sign);
                        fail_count++;
                    end
                    if (got.result_zero !== want.result_zero) begin
                        $error("result_zero: expected %b, got %b",
                               want.result_zero, got.result_zero);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(ternary_alu_eval(
                    s_tdata[OP_W-1:0],
                    s_tdata[OP_W +: WORD_W],
                    s_tdata[OP_W + WORD_W +: WORD_W],
                    s_tdata[OP_W + 2*WORD_W +: CNT_W]));
        end
        results_owed <= expected_results.size();
    end

endmodule

### bench/balanced_ternary_word_alu_core_tb.sv
`timescale 1ns / 100ps
module balanced_ternary_word_alu_core_tb;
    import bta_pkg::*;

    // Op code with no operation behind it; the block must return the zero word.
    localparam logic [OP_W-1:0]   OP_NONE     = 3'd7;

    localparam logic [WORD_W-1:0] ALL_POS     = 24'h555555;  // every trit +1
    localparam logic [WORD_W-1:0] ALL_NEG     = 24'hAAAAAA;  // every trit -1
    localparam logic [WORD_W-1:0] ALL_SPARE   = 24'hFFFFFF;  // every pair unused
    localparam logic [WORD_W-1:0] TOP_NEG     = 24'h800000;  // only the top trit, -1

    localparam int NUM_RANDOM  = 1025;
    localparam int TAIL_ITEMS  = 120;     // no idling on either side at the end
    localparam int LONG_HOLD   = 60;      // receiver hold-off that backs up the block
    localparam int CYCLE_LIMIT = 200000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // op, operand_a, operand_b, shift_count, zero pad
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;      // result_word, result_sign, result_zero, zero pad

    int fail_count;
    int results_owed;
    int results_checked;

    int cycle_count = 0;
    int op_hits [8];
    int tx_idle_pct = 0;
    bit quiet_tail  = 1'b0;
    int hold_asks   = 0;
    int holds_done  = 0;

    always #5 aclk = ~aclk;

    balanced_ternary_word_alu_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bta_alu_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .results_owed    (results_owed),
        .results_checked (results_checked)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("balanced_ternary_word_alu_core_tb: errors");
            $finish;
        end
    end

    // Build a word of trits 0, +1 and -1 only, no spare pairs.
    function automatic logic [WORD_W-1:0] clean_word(int ntrits);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < ntrits; i++) begin
            case ($urandom_range(0, 2))
                0:       w[2*i +: 2] = TRIT_ZERO;
                1:       w[2*i +: 2] = TRIT_POS;
                default: w[2*i +: 2] = TRIT_NEG;
            endcase
        end
        return w;
    endfunction

    // Mix of well-formed words, raw bit patterns, short values and extremes.
    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w = clean_word(DEF_WORD_TRITS);
            4, 5:       w = WORD_W'($urandom);
            6, 7:       w = clean_word($urandom_range(1, 4));
            default: begin
                case ($urandom_range(0, 4))
                    0:       w = '0;
                    1:       w = ALL_POS;
                    2:       w = ALL_NEG;
                    3:       w = ALL_SPARE;
                    default: w = TOP_NEG | clean_word(DEF_WORD_TRITS - 1);
                endcase
            end
        endcase
        return w;
    endfunction

    // Offer one item, hold it until accepted, then maybe go idle for a burst.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] a,
                             input logic [WORD_W-1:0] b, input logic [CNT_W-1:0] cnt);
        s_tdata  <= {1'b0, cnt, b, a, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        op_hits[op]++;
        if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Drop valid and wait until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    // Result side: ready most of the time, random stall bursts, one long hold-off
    // on request that backs the block up into its input.
    initial begin : result_side
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 199) == 0)
                case ($urandom_range(0, 2))
                    0:       tx_idle_pct = tx_idle_pct;   // keep sender setting as is
                    default: ;
                endcase
            if (hold_asks != holds_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (!quiet_tail && $urandom_range(0, 99) < 20 && cycle_count[8]) begin
                // stall bursts only while bit 8 of the cycle counter is set
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : item_side
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] cnt;

        foreach (op_hits[i])
            op_hits[i] = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, carries, wrap, every op, spare pairs, large shifts.
        send_item(OP_ADD, ALL_POS, ALL_POS, 4'd0);
        send_item(OP_ADD, ALL_NEG, ALL_NEG, 4'd0);
        send_item(OP_ADD, 24'h000001, 24'h000001, 4'd0);    // carry into trit 1
        send_item(OP_SUB, ALL_POS, ALL_POS, 4'd0);
        send_item(OP_SUB, '0, ALL_POS, 4'd0);
        send_item(OP_SUB, ALL_NEG, ALL_POS, 4'd0);
        send_item(OP_NEG, ALL_POS, '0, 4'd0);
        send_item(OP_NEG, '0, ALL_NEG, 4'd0);
        send_item(OP_NEG, ALL_SPARE, ALL_SPARE, 4'd15);     // spare pairs read as zero
        send_item(OP_MUL, ALL_POS, ALL_POS, 4'd0);
        send_item(OP_MUL, ALL_NEG, ALL_POS, 4'd0);
        send_item(OP_MUL, 24'h000001, 24'h123456, 4'd0);
        send_item(OP_MUL, '0, ALL_NEG, 4'd0);
        send_item(OP_MUL, ALL_SPARE, ALL_POS, 4'd0);
        send_item(OP_SHL, ALL_POS, '0, 4'd0);
        send_item(OP_SHL, ALL_NEG, '0, 4'd11);
        send_item(OP_SHL, ALL_POS, '0, 4'd12);              // count at width: zero
        send_item(OP_SHL, ALL_POS, '0, 4'd15);
        send_item(OP_SHR, ALL_NEG, '0, 4'd0);
        send_item(OP_SHR, TOP_NEG, '0, 4'd11);
        send_item(OP_SHR, ALL_POS, '0, 4'd12);
        send_item(OP_ABS, TOP_NEG | 24'h000001, '0, 4'd0);
        send_item(OP_ABS, ALL_POS, '0, 4'd0);
        send_item(OP_ABS, '0, '0, 4'd0);
        send_item(OP_NONE, ALL_POS, ALL_NEG, 4'd9);
        drain();

        // Random: idling level is picked anew every 64 items; one long receiver hold-off
        // and one full drain partway through.
        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k % 64 == 0)
                case ($urandom_range(0, 2))
                    0:       tx_idle_pct = 0;
                    1:       tx_idle_pct = 10;
                    default: tx_idle_pct = 35;
                endcase
            quiet_tail = (k >= NUM_RANDOM - TAIL_ITEMS);
            if (k == NUM_RANDOM / 2)
                hold_asks++;
            if (k == (NUM_RANDOM * 3) / 4)
                drain();
            op  = OP_W'($urandom_range(0, 7));
            cnt = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(0, DEF_WORD_TRITS - 1))
                                             : CNT_W'($urandom_range(DEF_WORD_TRITS, 15));
            send_item(op, rand_word(), rand_word(), cnt);
        end

        drain();
        repeat (4) @(posedge aclk);

        $display("run covered %0d items: add %0d sub %0d neg %0d mul %0d shl %0d shr %0d",
                 NUM_RANDOM + 25, op_hits[OP_ADD], op_hits[OP_SUB], op_hits[OP_NEG],
                 op_hits[OP_MUL], op_hits[OP_SHL], op_hits[OP_SHR]);
        $display("  abs %0d unused-op %0d; %0d results compared, %0d mismatches",
                 op_hits[OP_ABS], op_hits[OP_NONE], results_checked, fail_count);
        if (fail_count == 0)
            $display("balanced_ternary_word_alu_core_tb: clean");
        else
            $display("balanced_ternary_word_alu_core_tb: errors");
        $finish;
    end

endmodule
